### hw/rtl/pal_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pal_pkg;

	localparam int DATA_W        = 32;
	localparam int POS_W         = 8;
	localparam int FUNC_W        = 2;
	localparam int STATUS_W      = 2;
	localparam int LEN_W         = 7;
	localparam int CAP_W         = 7;
	localparam int DEPTH_DEFAULT = 64;
	localparam int GROUP_N       = 8;
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_INSERT = 2'd0,
		FUNC_GET    = 2'd1,
		FUNC_DELETE = 2'd2,
		FUNC_CLEAR  = 2'd3
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_BAD_POS = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_REDUCE
	} state_t;

	// per-cycle command broadcast to every cell of the row
	typedef struct packed {
		logic ins;
		logic del;
	} cell_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/pal_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module pal_cell
	import pal_pkg::*;
#(
	parameter int IDX = 0,
	parameter int IW  = 6
) (
	input  wire  logic              clk,
	input  wire  cell_ctl_t         ctl,
	input  wire  logic [IW-1:0]     cell_pos,
	input  wire  logic [DATA_W-1:0] value,
	input  wire  logic [DATA_W-1:0] left,
	input  wire  logic [DATA_W-1:0] right,
	output logic [DATA_W-1:0]       data,
	output logic [DATA_W-1:0]       hit_data
);

	localparam logic [IW-1:0] MY_IDX = IW'(IDX);

	logic [DATA_W-1:0] data_q;
	logic              at_pos;
	logic              above_pos;

	assign at_pos    = (cell_pos == MY_IDX);
	assign above_pos = (MY_IDX > cell_pos);

	// insert: take the new value at the position, take the lower neighbor above it
	// delete: take the upper neighbor from the position on
	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (at_pos) begin
				data_q <= value;
			end else if (above_pos) begin
				data_q <= left;
			end
		end else if (ctl.del) begin
			if (at_pos || above_pos) begin
				data_q <= right;
			end
		end
	end

	assign data     = data_q;
	assign hit_data = at_pos ? data_q : '0;

endmodule

`default_nettype wire

### hw/rtl/positional_array_list.sv
`timescale 1ns / 1ps
`default_nettype none
// Ordered list of 32-bit entries held in a row of register cells, one entry per cell.
// Requests do not overlap: req_stall holds until the previous response has loaded
//   the output register, which waits while an earlier response stays stalled; the row
//   applies a request in S_EXEC and a registered OR tree collects the read in S_REDUCE.
// Reset: arst_n clears the length, control state and output valid, and sets the
//   capacity to 64; entry cells are not reset and need no clearing pass.

module positional_array_list
	import pal_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  wire  logic                clk,
	input  wire  logic                arst_n,
	input  wire  logic                req_valid,
	output logic                      req_stall,
	input  wire  logic [FUNC_W-1:0]   func,
	input  wire  logic [POS_W-1:0]    pos,
	input  wire  logic [DATA_W-1:0]   value,
	output logic                      rsp_valid,
	input  wire  logic                rsp_stall,
	output logic [STATUS_W-1:0]       status,
	output logic [DATA_W-1:0]         read_value,
	output logic [LEN_W-1:0]          length,
	input  wire  logic                cfg_we,
	input  wire  logic [CAP_W-1:0]    cfg_wdata
);

	localparam int IW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int CMPW0 = (CW > POS_W) ? CW : POS_W;
	localparam int CMPW  = (CMPW0 > CAP_W) ? CMPW0 : CAP_W;
	localparam int NG    = (DEPTH + GROUP_N - 1) / GROUP_N;

	// Control and configuration registers
	state_t            state_q, state_d;
	logic [CAP_W-1:0]  cap_q;
	logic [CW-1:0]     count_q;
	logic              rsp_valid_q;

	// Request captured at acceptance
	func_t             func_s1;
	logic [POS_W-1:0]  pos_s1;
	logic [DATA_W-1:0] value_s1;

	// Results of the apply cycle
	status_t           status_s2;
	logic              rd_ok_s2;
	logic [DATA_W-1:0] grp_s2 [NG];

	// Output register
	logic [STATUS_W-1:0] status_q;
	logic [DATA_W-1:0]   read_value_q;
	logic [LEN_W-1:0]    length_q;

	// FSM outputs
	logic accept;
	logic exec;
	logic load_out;

	// Apply-cycle decode
	logic [CMPW-1:0]   posx, cntx, capx, ipos;
	status_t           status_d;
	logic              ins_ok, del_ok, rd_ok_d;
	logic [CW-1:0]     count_d;
	logic              count_we;
	cell_ctl_t         ctl;
	logic [IW-1:0]     cell_pos;

	// Cell row
	logic [DATA_W-1:0] cell_data [DEPTH];
	logic [DATA_W-1:0] cell_hit  [DEPTH];
	logic [DATA_W-1:0] grp_d     [NG];
	logic [DATA_W-1:0] rd_or;
	logic [CMPW-1:0]   lenx;

	// ---------------------------------------------------------------
	// Sequencer: take one request, apply it to the row, collect the read
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		exec      = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				exec    = 1'b1;
				state_d = S_REDUCE;
			end
			S_REDUCE: begin
				// hold here while the previous response still waits downstream
				if (!rsp_valid_q || !rsp_stall) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign accept = req_valid && !req_stall;

	// Capture the request; payload registers carry no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1  <= func_t'(func);
			pos_s1   <= pos;
			value_s1 <= value;
		end
	end

	// Capacity register; the effective capacity never exceeds the cell count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// ---------------------------------------------------------------
	// Decode the request against length and capacity
	// ---------------------------------------------------------------
	always_comb begin
		posx = CMPW'(pos_s1);
		cntx = CMPW'(count_q);
		capx = (CMPW'(cap_q) < CMPW'(DEPTH)) ? CMPW'(cap_q) : CMPW'(DEPTH);
		// insert past the end appends
		ipos = (posx > cntx) ? cntx : posx;

		status_d = ST_OK;
		ins_ok   = 1'b0;
		del_ok   = 1'b0;
		rd_ok_d  = 1'b0;
		count_d  = count_q;
		count_we = 1'b0;
		unique case (func_s1) inside
			FUNC_INSERT: begin
				if (posx > capx) begin
					status_d = ST_BAD_POS;
				end else if (cntx >= capx) begin
					status_d = ST_FULL;
				end else begin
					ins_ok   = 1'b1;
					count_d  = count_q + CW'(1);
					count_we = 1'b1;
				end
			end
			FUNC_GET, FUNC_DELETE: begin
				if (posx >= cntx) begin
					status_d = ST_BAD_POS;
				end else begin
					rd_ok_d = 1'b1;
					if (func_s1 == FUNC_DELETE) begin
						del_ok   = 1'b1;
						count_d  = count_q - CW'(1);
						count_we = 1'b1;
					end
				end
			end
			FUNC_CLEAR: begin
				count_d  = '0;
				count_we = 1'b1;
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	// Broadcast the command to the row only in the apply cycle
	assign ctl.ins  = exec && ins_ok;
	assign ctl.del  = exec && del_ok;
	assign cell_pos = ins_ok ? ipos[IW-1:0] : posx[IW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (exec && count_we) begin
			count_q <= count_d;
		end
	end

	// ---------------------------------------------------------------
	// Row of entry cells; each passes its entry to both neighbors
	// ---------------------------------------------------------------
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_W-1:0] left_w;
		logic [DATA_W-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_inner_l
			assign left_w = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_inner_r
			assign right_w = cell_data[i+1];
		end

		pal_cell #(
			.IDX (i),
			.IW  (IW)
		) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.cell_pos (cell_pos),
			.value    (value_s1),
			.left     (left_w),
			.right    (right_w),
			.data     (cell_data[i]),
			.hit_data (cell_hit[i])
		);
	end

	// ---------------------------------------------------------------
	// Read collection: OR the selected cell's entry in groups, then across groups.
	// Groups are sampled in the apply cycle, before the row shifts.
	// ---------------------------------------------------------------
	always_comb begin
		for (int g = 0; g < NG; g++) begin
			grp_d[g] = '0;
			for (int k = 0; k < GROUP_N; k++) begin
				if (g * GROUP_N + k < DEPTH) begin
					grp_d[g] = grp_d[g] | cell_hit[g * GROUP_N + k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			grp_s2    <= grp_d;
			status_s2 <= status_d;
			rd_ok_s2  <= rd_ok_d;
		end
	end

	always_comb begin
		rd_or = '0;
		for (int g = 0; g < NG; g++) begin
			rd_or = rd_or | grp_s2[g];
		end
	end

	// ---------------------------------------------------------------
	// Output register; a new response loads when the old one is taken
	// ---------------------------------------------------------------
	assign lenx = CMPW'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			status_q     <= status_s2;
			read_value_q <= rd_ok_s2 ? rd_or : '0;
			length_q     <= lenx[LEN_W-1:0];
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign status     = status_q;
	assign read_value = read_value_q;
	assign length     = length_q;

endmodule

`default_nettype wire
